/* hdl/aftg_pkg.sv */
// ----------------------------------------------------------------------------
// aftg_pkg
// Shared types and constants of the audio frame time stamp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package aftg_pkg;

  localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [29:0] NS_PER_FRAME = 30'd20000000;
  localparam int          NS_PER_MS    = 1000000;

  localparam int          OFFSET_MS_MAX   = 999;
  localparam int          OFFSET_MS_RESET = -180;
  localparam logic [15:0] HOLD_MS_RESET   = 16'd200;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [0:0] {
    REG_TIMING_OFFSET = 1'b0,
    REG_HOLD          = 1'b1
  } cfg_reg_t;

  // Offset is kept as a ready-made nanosecond value.
  typedef struct packed {
    logic signed [30:0] off_ns;
    logic [15:0]        hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/aftg_cfg.sv */
// ----------------------------------------------------------------------------
// aftg_cfg
// Configuration registers: saturated timing offset, scaled to nanoseconds at
// write time, and the hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module aftg_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [aftg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output aftg_pkg::cfg_t                        cfg
);
  import aftg_pkg::*;

  logic signed [10:0] raw_ms;
  logic signed [10:0] sat_ms;
  logic signed [31:0] prod_ns;
  logic signed [30:0] off_ns_r;
  logic signed [30:0] off_ns_nxt;
  logic [15:0]        hold_r;
  logic [15:0]        hold_nxt;

  always_comb begin
    raw_ms = $signed(cfg_wdata[10:0]);
    if (raw_ms > 11'(OFFSET_MS_MAX)) begin
      sat_ms = 11'(OFFSET_MS_MAX);
    end else if (raw_ms < -11'(OFFSET_MS_MAX)) begin
      sat_ms = -11'(OFFSET_MS_MAX);
    end else begin
      sat_ms = raw_ms;
    end
    prod_ns = 32'(sat_ms) * 32'(NS_PER_MS);

    off_ns_nxt = off_ns_r;
    hold_nxt   = hold_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMING_OFFSET: off_ns_nxt = prod_ns[30:0];
        REG_HOLD:          hold_nxt   = cfg_wdata[15:0];
        default: begin
          off_ns_nxt = off_ns_r;
          hold_nxt   = hold_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_ns_r <= 31'(OFFSET_MS_RESET * NS_PER_MS);
      hold_r   <= HOLD_MS_RESET;
    end else begin
      off_ns_r <= off_ns_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign cfg.off_ns  = off_ns_r;
  assign cfg.hold_ms = hold_r;

endmodule

`default_nettype wire

/* hdl/audio_frame_timestamp_generator.sv */
// ----------------------------------------------------------------------------
// audio_frame_timestamp_generator
// Stamps audio frames with anchor time plus 20 ms per frame plus an offset.
// ----------------------------------------------------------------------------
// The block takes one frame word per clock while in_tready is high. The word
// is held in an input register (where its nanoseconds are already folded
// below one second), and one pass of adds and compares fills the result
// register with its stamp. Words whose connected flag is low are taken and
// dropped without any effect. A burst restarts on the first frame, after a
// frame with zero RSSI, or after a gap above hold_ms; the running stamp of the
// burst is kept in registers and advanced by 20 ms per frame, so no divider
// is needed. While a result waits, a word is still taken if the input register
// is empty; once both registers hold a word, in_tready follows out_tready in
// the same cycle.
`default_nettype none

module audio_frame_timestamp_generator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [aftg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // frame_sec[31:0], frame_nsec[61:32], rssi[69:62], now_ms[101:70], zero pad
  input  wire logic [aftg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // connected[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // stamp_sec[31:0], stamp_nsec[61:32], zero pad
  output logic [aftg_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import aftg_pkg::*;

  cfg_t cfg;

  aftg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register.
  logic        in_valid_r;
  logic        conn_r;
  logic [31:0] fsec_r;
  logic [29:0] fnsec_r;
  logic        keyed_in_r;
  logic [31:0] now_r;
  logic [31:0] cap_sec;
  logic [29:0] cap_nsec;

  // Burst state. keyed_r also serves as the anchor-valid flag: both are set
  // and cleared together.
  logic        keyed_r;
  logic        keyed_nxt;
  logic [31:0] last_ms_r;
  logic [31:0] bf_r;
  logic [31:0] bf_nxt;
  logic [31:0] anc_sec_r;
  logic [29:0] anc_nsec_r;
  logic [31:0] anc_sec_nxt;
  logic [29:0] anc_nsec_nxt;
  logic [31:0] acc_sec_r;
  logic [29:0] acc_nsec_r;
  logic [31:0] acc_sec_nxt;
  logic [29:0] acc_nsec_nxt;

  // Result register.
  logic        out_valid_r;
  logic [31:0] stamp_sec_r;
  logic [29:0] stamp_nsec_r;

  logic        advance;
  logic        work;
  logic [31:0] gap;
  logic        restart;
  logic [31:0] base_sec;
  logic [29:0] base_nsec;
  logic signed [31:0] sum_ns;
  logic [31:0] st_sec;
  logic [29:0] st_nsec;
  logic [29:0] adv_nsec;
  logic [31:0] adv_sec;
  logic [29:0] adv_nsec_n;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign work      = in_valid_r && advance && conn_r;

  always_comb begin
    if (in_tdata[61:32] >= NS_PER_SEC) begin
      cap_nsec = in_tdata[61:32] - NS_PER_SEC;
      cap_sec  = in_tdata[31:0] + 32'd1;
    end else begin
      cap_nsec = in_tdata[61:32];
      cap_sec  = in_tdata[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      conn_r     <= in_tuser;
      fsec_r     <= cap_sec;
      fnsec_r    <= cap_nsec;
      keyed_in_r <= (in_tdata[69:62] != 8'd0);
      now_r      <= in_tdata[101:70];
    end
  end

  always_comb begin
    gap     = now_r - last_ms_r;
    restart = !keyed_r || (gap > {16'd0, cfg.hold_ms});

    base_sec  = restart ? fsec_r  : acc_sec_r;
    base_nsec = restart ? fnsec_r : acc_nsec_r;

    sum_ns = $signed({2'b00, base_nsec}) + 32'(cfg.off_ns);
    if (sum_ns >= $signed({2'b00, NS_PER_SEC})) begin
      st_nsec = 30'(sum_ns - $signed({2'b00, NS_PER_SEC}));
      st_sec  = base_sec + 32'd1;
    end else if (sum_ns < 32'sd0) begin
      st_nsec = 30'(sum_ns + $signed({2'b00, NS_PER_SEC}));
      st_sec  = base_sec - 32'd1;
    end else begin
      st_nsec = sum_ns[29:0];
      st_sec  = base_sec;
    end

    // Running stamp for the next frame of the burst.
    adv_nsec = base_nsec + NS_PER_FRAME;
    if (adv_nsec >= NS_PER_SEC) begin
      adv_nsec_n = adv_nsec - NS_PER_SEC;
      adv_sec    = base_sec + 32'd1;
    end else begin
      adv_nsec_n = adv_nsec;
      adv_sec    = base_sec;
    end

    anc_sec_nxt  = restart ? fsec_r  : anc_sec_r;
    anc_nsec_nxt = restart ? fnsec_r : anc_nsec_r;
    bf_nxt       = (restart ? 32'd0 : bf_r) + 32'd1;

    // When the frame count wraps, the burst offset starts over at the anchor.
    if (bf_nxt == 32'd0) begin
      acc_sec_nxt  = anc_sec_nxt;
      acc_nsec_nxt = anc_nsec_nxt;
    end else begin
      acc_sec_nxt  = adv_sec;
      acc_nsec_nxt = adv_nsec_n;
    end

    keyed_nxt = keyed_in_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r <= 1'b0;
    end else if (work) begin
      keyed_r <= keyed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      last_ms_r  <= now_r;
      bf_r       <= bf_nxt;
      anc_sec_r  <= anc_sec_nxt;
      anc_nsec_r <= anc_nsec_nxt;
      acc_sec_r  <= acc_sec_nxt;
      acc_nsec_r <= acc_nsec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && conn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      stamp_sec_r  <= st_sec;
      stamp_nsec_r <= st_nsec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, stamp_nsec_r, stamp_sec_r};

endmodule

`default_nettype wire

/* hdl/aftg_checker.sv */
// ----------------------------------------------------------------------------
// aftg_checker
// Port-level checks of the time stamp generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aftg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [aftg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import aftg_pkg::*;

  // The result register comes up empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // Nanoseconds of every stamp are normalized below one second.
  a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[61:32] < NS_PER_SEC))
    else $error("stamp nanoseconds not below one second");

  // With no result waiting, the input side is never stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind audio_frame_timestamp_generator aftg_checker u_aftg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
